// ----- hw/rtl/mdpe_pkg.sv -----
// shared widths, constants and types of the meter disc power estimator
package mdpe_pkg;

  localparam int MvWidth      = 12;
  localparam int RevsWidth    = 12;
  localparam int SecondsWidth = 20;
  localparam int PowerWidth   = 26;
  localparam int ProdWidth    = RevsWidth + SecondsWidth;
  localparam int CfgIdxWidth  = 1;
  localparam int CfgDataWidth = 12;
  localparam int StepWidth    = $clog2(PowerWidth);

  localparam logic [MvWidth-1:0]      ThresholdReset = MvWidth'(2700);
  localparam logic [RevsWidth-1:0]    RevsReset      = RevsWidth'(71);
  localparam logic [SecondsWidth-1:0] SecondsMax     = {SecondsWidth{1'b1}};
  localparam logic [PowerWidth-1:0]   PowerNumerator = PowerWidth'(36000000);

  localparam logic [StepWidth-1:0] MulSteps = StepWidth'(RevsWidth - 1);
  localparam logic [StepWidth-1:0] DivSteps = StepWidth'(PowerWidth - 1);

  // register indexes of the configuration port
  localparam logic [CfgIdxWidth-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CFG_REVS      = 1'b1;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_HOLD
  } mdpe_state_t;

endpackage

// ----- hw/rtl/mdpe_if.sv -----
// channel interfaces: sensor word in, result word out, register writes
interface mdpe_in_if import mdpe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [MvWidth-1:0] sample_mv;

  modport source (output valid, output mode, output sample_mv, input ready);
  modport sink (input valid, input mode, input sample_mv, output ready);
endinterface

interface mdpe_out_if import mdpe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [SecondsWidth-1:0] period_seconds;
  logic [PowerWidth-1:0]   power_deciwatts;
  logic                    zero_period;

  modport source (output valid, output period_seconds, output power_deciwatts,
                  output zero_period, input ready);
  modport sink (input valid, input period_seconds, input power_deciwatts,
                input zero_period, output ready);
endinterface

interface mdpe_cfg_if import mdpe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CfgIdxWidth-1:0]  index;
  logic [CfgDataWidth-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/meter_disc_power_estimator.sv -----
// Meter disc power estimator. Each input word is a sensor sample in mV (mode 0) or a
// one-second tick (mode 1). A sample above threshold_mv after one at or below it is a
// red-mark edge; the first edge starts timing, every later edge yields one result word
// with the period in whole seconds and 36000000 / (revolutions_per_kwh * period) in
// tenths of a watt. Ticks and samples that are not a timed edge leave the block ready
// for the next word. A timed edge holds off the next word through the accepting state,
// the bit-serial multiplier (one bit of revolutions_per_kwh per cycle), the restoring
// divider (one quotient bit per cycle) and the hand-over to the output register, which
// waits while that register holds an earlier word. The output register holds a finished
// word until it is taken. Register writes are taken every cycle.
module meter_disc_power_estimator import mdpe_pkg::*; (
  input logic        clk,
  input logic        rst,
  mdpe_in_if.sink    samples,
  mdpe_out_if.source results,
  mdpe_cfg_if.sink   cfg
);

  mdpe_state_t state, state_next;

  logic [MvWidth-1:0]      threshold;
  logic [RevsWidth-1:0]    revs;
  logic                    mark_visible;
  logic                    timing_started;
  logic [SecondsWidth-1:0] elapsed;

  logic [StepWidth-1:0]    step;
  logic [SecondsWidth-1:0] secs;
  logic [ProdWidth-1:0]    mcand;
  logic [RevsWidth-1:0]    mplier;
  logic [ProdWidth-1:0]    prod;
  logic [PowerWidth-1:0]   quot;
  logic [PowerWidth-1:0]   rem;

  logic                    out_valid;
  logic [SecondsWidth-1:0] out_period;
  logic [PowerWidth-1:0]   out_power;
  logic                    out_zero;

  logic in_fire;
  logic above;
  logic new_edge;
  logic timed_edge;
  logic load_out;

  logic [PowerWidth:0]   trial;
  logic                  fits;
  logic [PowerWidth-1:0] rem_next;

  assign in_fire    = samples.valid && samples.ready;
  assign above      = samples.sample_mv > threshold;
  assign new_edge   = (samples.mode == MODE_SAMPLE) && above && !mark_visible;
  assign timed_edge = new_edge && timing_started;

  // one restoring division step: bring down the next dividend bit
  assign trial    = {rem, quot[PowerWidth-1]};
  assign fits     = {{(ProdWidth-PowerWidth-1){1'b0}}, trial} >= prod;
  assign rem_next = fits ? PowerWidth'(trial - prod[PowerWidth:0]) : trial[PowerWidth-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire && timed_edge) state_next = ST_MUL;
      ST_MUL:  if (step == '0) state_next = ST_DIV;
      ST_DIV:  if (step == '0) state_next = ST_HOLD;
      ST_HOLD: if (!out_valid || results.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    samples.ready = (state == ST_IDLE);
    load_out      = (state == ST_HOLD) && (!out_valid || results.ready);
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      threshold      <= ThresholdReset;
      revs           <= RevsReset;
      mark_visible   <= 1'b0;
      timing_started <= 1'b0;
      elapsed        <= '0;
      step           <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg.valid) begin
        if (cfg.index == CFG_THRESHOLD) threshold <= cfg.data;
        if (cfg.index == CFG_REVS)      revs      <= cfg.data;
      end

      if (in_fire) begin
        if (samples.mode == MODE_TICK) begin
          if (elapsed != SecondsMax) elapsed <= elapsed + 1'b1;
        end else if (!above) begin
          mark_visible <= 1'b0;
        end else if (!mark_visible) begin
          mark_visible   <= 1'b1;
          timing_started <= 1'b1;
          elapsed        <= '0;
        end
      end

      priority if (state == ST_IDLE) begin
        step <= MulSteps;
      end else if (step == '0) begin
        step <= DivSteps;
      end else begin
        step <= step - 1'b1;
      end

      if (load_out)                       out_valid <= 1'b1;
      else if (results.ready)             out_valid <= 1'b0;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        secs   <= elapsed;
        mcand  <= ProdWidth'(elapsed);
        mplier <= revs;
        prod   <= '0;
        quot   <= PowerNumerator;
        rem    <= '0;
      end
      ST_MUL: begin
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
      end
      ST_DIV: begin
        rem  <= rem_next;
        quot <= {quot[PowerWidth-2:0], fits};
      end
      ST_HOLD: begin
        if (load_out) begin
          out_period <= secs;
          out_power  <= (prod == '0) ? PowerNumerator : quot;
          out_zero   <= (secs == '0);
        end
      end
      default: ;
    endcase
  end

  assign results.valid           = out_valid;
  assign results.period_seconds  = out_period;
  assign results.power_deciwatts = out_power;
  assign results.zero_period     = out_zero;

endmodule

// ----- hw/rtl/mdpe_checker.sv -----
// port-level checks of the meter disc power estimator
module mdpe_checker import mdpe_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SecondsWidth-1:0] period_seconds,
  input logic [PowerWidth-1:0]   power_deciwatts,
  input logic                    zero_period
);

  // a stalled result word stays put
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(period_seconds)
      && $stable(power_deciwatts) && $stable(zero_period))
    else $error("result word changed while stalled");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> zero_period == (period_seconds == '0))
    else $error("zero period flag disagrees with period");

  // zero period saturates power, and power never exceeds the numerator
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (power_deciwatts <= PowerNumerator)
      && (!zero_period || power_deciwatts == PowerNumerator))
    else $error("power out of range");

endmodule

bind meter_disc_power_estimator mdpe_checker u_mdpe_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .period_seconds  (results.period_seconds),
  .power_deciwatts (results.power_deciwatts),
  .zero_period     (results.zero_period)
);

// ----- test/tb_meter_disc_power_estimator.sv -----
// testbench for the meter disc power estimator: directed table, random edge streams, self-check
module tb_meter_disc_power_estimator;
  import mdpe_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 48;
  localparam int unsigned HoldCycles  = 500;
  localparam int unsigned PhaseWords  = 185;
  localparam int unsigned PauseEvery  = 150;

  typedef struct packed {
    logic [SecondsWidth-1:0] period;
    logic [PowerWidth-1:0]   power;
    logic                    zero;
  } meter_result_t;

  typedef enum {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic                   mode;
    logic [CfgIdxWidth-1:0] reg_idx;
    logic [MvWidth-1:0]     value;
    int unsigned            reps;
    bit                     has_want;
    meter_result_t          want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  mdpe_in_if  samples_ch ();
  mdpe_out_if results_ch ();
  mdpe_cfg_if cfg_ch ();

  meter_disc_power_estimator dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of registers and state
  logic [MvWidth-1:0]      thr_mv    = ThresholdReset;
  logic [RevsWidth-1:0]    revs_kwh  = RevsReset;
  logic                    mark_seen = 1'b0;
  logic                    timing_on = 1'b0;
  logic [SecondsWidth-1:0] sec_count = '0;

  meter_result_t pending_readings[$];
  stim_row_t     dir_tab[$];

  logic          cur_has_want;
  meter_result_t cur_want;
  int unsigned   tx_idle_pct;
  int unsigned   rx_idle_pct;
  logic          rx_hold = 1'b0;
  int unsigned   err_cnt = 0;
  int unsigned   cycle_cnt = 0;
  event          long_stall_ev;

  task automatic report(input string msg);
    $display("error: %s", msg);
    err_cnt++;
  endtask

  function automatic bit predict_reading(input logic m, input logic [MvWidth-1:0] s,
                                         output meter_result_t r);
    logic [ProdWidth-1:0] den;
    r = '0;
    if (m == MODE_TICK) begin
      if (sec_count != SecondsMax) sec_count++;
      return 1'b0;
    end
    if (s <= thr_mv) begin
      mark_seen = 1'b0;
      return 1'b0;
    end
    if (mark_seen) return 1'b0;
    mark_seen = 1'b1;
    // first edge only starts timing
    if (!timing_on) begin
      timing_on = 1'b1;
      sec_count = '0;
      return 1'b0;
    end
    den = ProdWidth'(revs_kwh) * ProdWidth'(sec_count);
    r.period = sec_count;
    r.power  = (den == '0) ? PowerNumerator : PowerWidth'(ProdWidth'(PowerNumerator) / den);
    r.zero   = (sec_count == '0);
    sec_count = '0;
    return 1'b1;
  endfunction

  // accepted input words and register writes
  always @(posedge clk) begin
    meter_result_t r;
    bit got;
    if (!rst) begin
      if (samples_ch.valid && samples_ch.ready) begin
        got = predict_reading(samples_ch.mode, samples_ch.sample_mv, r);
        if (cur_has_want) pending_readings.push_back(cur_want);
        else if (got) pending_readings.push_back(r);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_THRESHOLD: thr_mv = cfg_ch.data;
          CFG_REVS:      revs_kwh = cfg_ch.data;
        endcase
      end
    end
  end

  // result words against the oldest expectation
  always @(posedge clk) begin
    meter_result_t w;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (pending_readings.size() == 0) begin
        report($sformatf("unexpected result period %0d power %0d zero %0d",
                         results_ch.period_seconds, results_ch.power_deciwatts,
                         results_ch.zero_period));
      end else begin
        w = pending_readings.pop_front();
        if (results_ch.period_seconds !== w.period)
          report($sformatf("period_seconds got %0d expected %0d",
                           results_ch.period_seconds, w.period));
        if (results_ch.power_deciwatts !== w.power)
          report($sformatf("power_deciwatts got %0d expected %0d",
                           results_ch.power_deciwatts, w.power));
        if (results_ch.zero_period !== w.zero)
          report($sformatf("zero_period got %0d expected %0d",
                           results_ch.zero_period, w.zero));
      end
    end
  end

  always @(posedge clk) begin
    if (rx_hold) results_ch.ready <= 1'b0;
    else results_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // long receiver hold-off so the block backs up into its input
  always begin
    @(long_stall_ev);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_readings.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_word(input logic m, input logic [MvWidth-1:0] s, input bit has_w,
                           input meter_result_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      samples_ch.valid <= 1'b0;
      @(posedge clk);
    end
    samples_ch.valid     <= 1'b1;
    samples_ch.mode      <= m;
    samples_ch.sample_mv <= s;
    cur_has_want         <= has_w;
    cur_want             <= w;
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] d);
    samples_ch.valid <= 1'b0;
    // let the last accepted word reach the expectation queue first
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic stim_row_t word_row(input logic m, input logic [MvWidth-1:0] v,
                                         input int unsigned reps);
    stim_row_t row;
    row = '{ROW_WORD, m, CFG_THRESHOLD, v, reps, 1'b0, '0};
    return row;
  endfunction

  function automatic stim_row_t checked_row(input logic [MvWidth-1:0] v,
                                            input logic [SecondsWidth-1:0] p,
                                            input logic [PowerWidth-1:0] pw, input logic z);
    stim_row_t row;
    row = '{ROW_WORD, MODE_SAMPLE, CFG_THRESHOLD, v, 1, 1'b1, '{p, pw, z}};
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CfgIdxWidth-1:0] idx,
                                        input logic [CfgDataWidth-1:0] d);
    stim_row_t row;
    row = '{ROW_REG, MODE_SAMPLE, idx, d, 1, 1'b0, '0};
    return row;
  endfunction

  function automatic logic [MvWidth-1:0] low_level();
    return MvWidth'($urandom_range(thr_mv, 0));
  endfunction

  function automatic logic [MvWidth-1:0] high_level();
    if (thr_mv == {MvWidth{1'b1}}) return {MvWidth{1'b1}};
    return MvWidth'($urandom_range(4095, thr_mv + 1));
  endfunction

  // mostly tick runs followed by a low then high sample, plus noise and broken edges
  task automatic run_phase(input int unsigned n_words);
    int unsigned sent;
    int unsigned next_pause;
    int unsigned ticks;
    int unsigned k;
    sent = 0;
    next_pause = PauseEvery;
    while (sent < n_words) begin
      if ($urandom_range(99) < 15) begin
        send_word(1'($urandom_range(1)), MvWidth'($urandom_range(4095)), 1'b0, '0);
        sent++;
      end else begin
        ticks = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(5);
        for (k = 0; k < ticks; k++) send_word(MODE_TICK, MvWidth'($urandom_range(4095)), 1'b0, '0);
        sent += ticks;
        // occasionally skip the low sample so the high one is no edge
        if ($urandom_range(9) != 0) begin
          ticks = $urandom_range(2, 1);
          for (k = 0; k < ticks; k++) send_word(MODE_SAMPLE, low_level(), 1'b0, '0);
          sent += ticks;
        end
        ticks = $urandom_range(2, 1);
        for (k = 0; k < ticks; k++) send_word(MODE_SAMPLE, high_level(), 1'b0, '0);
        sent += ticks;
      end
      if (sent >= next_pause) begin
        samples_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0) @(posedge clk);
        @(posedge clk);
        next_pause += PauseEvery;
      end
    end
  endtask

  initial begin
    int unsigned ph;
    logic [CfgDataWidth-1:0] thr_val;
    logic [CfgDataWidth-1:0] revs_val;
    rst = 1'b1;
    samples_ch.valid = 1'b0;
    samples_ch.mode = MODE_SAMPLE;
    samples_ch.sample_mv = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_THRESHOLD;
    cfg_ch.data = '0;
    results_ch.ready = 1'b0;
    cur_has_want = 1'b0;
    cur_want = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;

    // ticks before the first edge are cleared by it
    dir_tab.push_back(word_row(MODE_TICK, 12'd0, 5));
    dir_tab.push_back(word_row(MODE_SAMPLE, 12'd4095, 1));
    dir_tab.push_back(word_row(MODE_SAMPLE, 12'd4095, 1));
    dir_tab.push_back(word_row(MODE_SAMPLE, 12'd2700, 1));
    dir_tab.push_back(checked_row(12'd2701, 20'd0, 26'd36000000, 1'b1));
    dir_tab.push_back(word_row(MODE_SAMPLE, 12'd0, 1));
    dir_tab.push_back(word_row(MODE_TICK, 12'd4095, 3));
    dir_tab.push_back(word_row(MODE_SAMPLE, 12'd2701, 1));
    // tick leaves the mark visible, so the next high sample is no edge
    dir_tab.push_back(word_row(MODE_TICK, 12'd0, 1));
    dir_tab.push_back(word_row(MODE_SAMPLE, 12'd4095, 1));
    dir_tab.push_back(word_row(MODE_SAMPLE, 12'd0, 1));
    // a longer period
    dir_tab.push_back(word_row(MODE_TICK, 12'd0, 300));
    dir_tab.push_back(word_row(MODE_SAMPLE, 12'd4095, 1));
    dir_tab.push_back(reg_row(CFG_REVS, 12'd0));
    dir_tab.push_back(word_row(MODE_SAMPLE, 12'd0, 1));
    dir_tab.push_back(word_row(MODE_TICK, 12'd0, 3));
    dir_tab.push_back(checked_row(12'd4095, 20'd3, 26'd36000000, 1'b0));
    dir_tab.push_back(word_row(MODE_SAMPLE, 12'd0, 1));
    dir_tab.push_back(checked_row(12'd4095, 20'd0, 26'd36000000, 1'b1));
    dir_tab.push_back(reg_row(CFG_REVS, 12'd1));
    dir_tab.push_back(word_row(MODE_SAMPLE, 12'd0, 1));
    dir_tab.push_back(word_row(MODE_TICK, 12'd0, 1));
    dir_tab.push_back(checked_row(12'd4095, 20'd1, 26'd36000000, 1'b0));
    dir_tab.push_back(reg_row(CFG_THRESHOLD, 12'd0));
    dir_tab.push_back(word_row(MODE_SAMPLE, 12'd0, 1));
    dir_tab.push_back(checked_row(12'd1, 20'd0, 26'd36000000, 1'b1));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
      end else begin
        repeat (dir_tab[i].reps)
          send_word(dir_tab[i].mode, dir_tab[i].value, dir_tab[i].has_want, dir_tab[i].want);
      end
    end

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin thr_val = 12'd2700; revs_val = 12'd71; end
        1: begin thr_val = 12'd0; revs_val = 12'd4095; end
        2: begin thr_val = 12'd4095; revs_val = 12'd1; end
        4: begin thr_val = 12'd1500; revs_val = 12'd1; end
        default: begin
          thr_val = CfgDataWidth'($urandom_range(4095));
          revs_val = CfgDataWidth'($urandom_range(4095, 1));
        end
      endcase
      write_reg(CFG_THRESHOLD, thr_val);
      write_reg(CFG_REVS, revs_val);
      if (ph < 2) begin
        tx_idle_pct = 24;
        rx_idle_pct = 80;
      end else if (ph < 4) begin
        tx_idle_pct = 80;
        rx_idle_pct = 24;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph == 0) -> long_stall_ev;
      run_phase(PhaseWords);
    end

    samples_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
